### rtl/core/in_order_release_buffer_defines.svh
// Assertion macros for the in-order release buffer sequencer.
`ifndef IN_ORDER_RELEASE_BUFFER_DEFINES_SVH
`define IN_ORDER_RELEASE_BUFFER_DEFINES_SVH

// Checked only outside reset.
`define IORB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define IORB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/iorb_pkg.sv
// Shared constants for the in-order release buffer.
package iorb_pkg;

  localparam int ID_BITS = 7;
  localparam logic [ID_BITS-1:0] STREAM_LENGTH_RESET = 7'd64;

endpackage

### rtl/core/iorb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iorb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/iorb_seq.sv
// Slot store, fill bits and release sequencer of the in-order release buffer.
`include "in_order_release_buffer_defines.svh"

module iorb_seq import iorb_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ID_BITS-1:0]   stream_length,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ID_BITS-1:0]   slot_id,
  input  logic [WORD_BITS-1:0] payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] released_word,
  output logic                 last_of_run
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_WAIT
  } state_t;

  state_t               state;
  logic [LEN_W-1:0]     next_position;
  logic [DEPTH-1:0]     filled;
  logic                 run_last;

  logic [LEN_W-1:0]     eff_len;
  logic                 in_take;
  logic                 id_ok;
  logic [ID_BITS-1:0]   pos_full;
  logic [ADDR_W-1:0]    pos;
  logic                 pos_hit;
  logic [LEN_W-1:0]     nxt;
  logic                 more;
  logic                 out_load;
  logic [WORD_BITS-1:0] rd_data;

  // Lengths above the buffer depth act as the depth.
  assign eff_len  = (stream_length > ID_BITS'(DEPTH)) ? LEN_W'(DEPTH)
                                                      : stream_length[LEN_W-1:0];
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign id_ok    = (slot_id != '0) && (slot_id <= ID_BITS'(eff_len));
  assign pos_full = slot_id - ID_BITS'(1);
  assign pos      = pos_full[ADDR_W-1:0];
  assign pos_hit  = (LEN_W'(pos) == next_position);

  // Shared step unit: position increment and the look-ahead for the last flag.
  assign nxt      = next_position + LEN_W'(1);
  assign more     = (nxt < eff_len) && filled[nxt[ADDR_W-1:0]];
  assign out_load = (state == ST_WAIT) && (!out_valid || !out_stall);

  iorb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (in_take && id_ok),
    .wr_addr (pos),
    .wr_data (payload),
    .rd_en   (state == ST_RD),
    .rd_addr (next_position[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      next_position <= '0;
      filled        <= '0;
      run_last      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take && id_ok) begin
            filled[pos] <= 1'b1;
            if (pos_hit) begin
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          // read issued this cycle; data lands next cycle
          run_last <= !more;
          state    <= ST_WAIT;
        end
        ST_WAIT: begin
          if (out_load) begin
            out_valid     <= 1'b1;
            released_word <= rd_data;
            last_of_run   <= run_last;
            next_position <= nxt;
            state         <= run_last ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `IORB_ASSERT(a_pos_bound, next_position <= LEN_W'(DEPTH), "release position past depth")
  `IORB_ASSERT(a_pos_step, out_load |=> (next_position == $past(next_position) + LEN_W'(1)), "release position did not advance by one")
  `IORB_ASSERT(a_rd_filled, (state == ST_RD) |-> filled[next_position[ADDR_W-1:0]], "read of an unfilled slot")
  `IORB_ASSERT_ALWAYS(a_filled_rst, rst |=> (filled == '0), "fill bits not cleared by reset")

endmodule

### rtl/core/in_order_release_buffer.sv
// Top level of the in-order release buffer: length register and sequencer.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  in       | in_valid / in_stall    | slot_id, payload
//  out      | out_valid / out_stall  | released_word, last_of_run
//  cfg      | cfg_wr_en              | cfg_wr_data (stream_length)
//
// An input transaction is taken while in_stall is low; a dropped or out-of-order id is done then.
// Each released word of a run passes a registered slot RAM read, then an output
// register load; in_stall stays high until the last word is loaded.
// The output register lets the next input transaction in while the last word waits.
// Reset clears fill bits and the release position at once; no clearing pass.
// out_stall holds the sequencer in its load step; nothing is lost.
module in_order_release_buffer import iorb_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [ID_BITS-1:0]   cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ID_BITS-1:0]   slot_id,
  input  logic [WORD_BITS-1:0] payload,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_BITS-1:0] released_word,
  output logic                 last_of_run
);

  logic [ID_BITS-1:0] stream_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_length <= STREAM_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      stream_length <= cfg_wr_data;
    end
  end

  iorb_seq #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .stream_length (stream_length),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .slot_id       (slot_id),
    .payload       (payload),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .released_word (released_word),
    .last_of_run   (last_of_run)
  );

endmodule
